/* hw/rtl/cpk_pkg.sv */
// Shared types, constants and register codes of the cable plotter kinematics block.
// No dependencies; the RTL files refer to this package by scoped names, the bench imports it.
package cpk_pkg;

   localparam int COORD_FRACTION_BITS = 4;
   localparam int SCALE_FRACTION_BITS = 8;
   localparam int STEP_SHIFT          = COORD_FRACTION_BITS + SCALE_FRACTION_BITS;

   localparam int COORD_W   = 16;
   localparam int CLAMP_W   = 15;
   localparam int MAG_W     = 16;
   localparam int LEN_W     = 17;
   localparam int STEP_W    = 21;
   localparam int SPM_W     = 16;
   localparam int PROD_W    = LEN_W + SPM_W;
   localparam int RAD_W     = 35;
   localparam int ROOT_W    = 18;
   localparam int ISQRT_STEPS = ROOT_W;
   localparam int ISQRT_CNT_W = $clog2(ISQRT_STEPS);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] REG_BOARD_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BOARD_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR_Y     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR_GAP   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STEPS_PER_MM = 3'd4;

   localparam logic [CLAMP_W-1:0]        BOARD_WIDTH_RST  = 15'd16000;
   localparam logic [CLAMP_W-1:0]        BOARD_HEIGHT_RST = 15'd16000;
   localparam logic signed [COORD_W-1:0] ANCHOR_Y_RST     = 16'sd0;
   localparam logic [CLAMP_W-1:0]        ANCHOR_GAP_RST   = 15'd0;
   localparam logic [SPM_W-1:0]          STEPS_PER_MM_RST = 16'd1280;

   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_SET  = 1'b1;

   typedef struct packed {
      logic [CLAMP_W-1:0]        board_width;
      logic [CLAMP_W-1:0]        board_height;
      logic signed [COORD_W-1:0] anchor_y;
      logic [CLAMP_W-1:0]        anchor_gap;
      logic [SPM_W-1:0]          steps_per_mm;
   } cpk_cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLAMP,
      S_SQ_Y,
      S_SQ_L,
      S_SQ_R,
      S_RL_GO,
      S_RL_WAIT,
      S_RR_GO,
      S_RR_WAIT,
      S_DIFF,
      S_STEP_L,
      S_STEP_R,
      S_FINISH
   } cpk_state_type;

endpackage

/* hw/rtl/cpk_req_if.sv */
// Request channel of the cable plotter kinematics block: valid/ready plus target point.
// Depends on cpk_pkg for field widths.
interface cpk_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic signed [cpk_pkg::COORD_W-1:0]   target_x;
   logic signed [cpk_pkg::COORD_W-1:0]   target_y;

   modport source (output valid, operation, target_x, target_y, input ready);
   modport sink   (input valid, operation, target_x, target_y, output ready);
endinterface

/* hw/rtl/cpk_rsp_if.sv */
// Response channel of the cable plotter kinematics block: valid/ready plus move result.
// Depends on cpk_pkg for field widths.
interface cpk_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cpk_pkg::CLAMP_W-1:0]   clamped_x;
   logic [cpk_pkg::CLAMP_W-1:0]   clamped_y;
   logic [cpk_pkg::LEN_W-1:0]     new_length_left;
   logic [cpk_pkg::LEN_W-1:0]     new_length_right;
   logic [cpk_pkg::STEP_W-1:0]    step_count_left;
   logic [cpk_pkg::STEP_W-1:0]    step_count_right;
   logic                          dir_level_left;
   logic                          dir_level_right;

   modport source (output valid, clamped_x, clamped_y, new_length_left, new_length_right,
                   step_count_left, step_count_right, dir_level_left, dir_level_right,
                   input ready);
   modport sink   (input valid, clamped_x, clamped_y, new_length_left, new_length_right,
                   step_count_left, step_count_right, dir_level_left, dir_level_right,
                   output ready);
endinterface

/* hw/rtl/cpk_csr.sv */
// Configuration registers of the cable plotter kinematics block (write only).
// Depends on cpk_pkg for register codes, reset values and the config struct.
module cpk_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              we,
   input  logic [cpk_pkg::CSR_INDEX_W-1:0]   index,
   input  logic [cpk_pkg::CSR_DATA_W-1:0]    wdata,
   output cpk_pkg::cpk_cfg_type              cfg
);

   cpk_pkg::cpk_cfg_type cfg_ff;
   cpk_pkg::cpk_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (we) begin
         case (index)
            cpk_pkg::REG_BOARD_WIDTH:  cfg_in.board_width  = wdata[cpk_pkg::CLAMP_W-1:0];
            cpk_pkg::REG_BOARD_HEIGHT: cfg_in.board_height = wdata[cpk_pkg::CLAMP_W-1:0];
            cpk_pkg::REG_ANCHOR_Y:     cfg_in.anchor_y     = $signed(wdata);
            cpk_pkg::REG_ANCHOR_GAP:   cfg_in.anchor_gap   = wdata[cpk_pkg::CLAMP_W-1:0];
            cpk_pkg::REG_STEPS_PER_MM: cfg_in.steps_per_mm = wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.board_width  <= cpk_pkg::BOARD_WIDTH_RST;
         cfg_ff.board_height <= cpk_pkg::BOARD_HEIGHT_RST;
         cfg_ff.anchor_y     <= cpk_pkg::ANCHOR_Y_RST;
         cfg_ff.anchor_gap   <= cpk_pkg::ANCHOR_GAP_RST;
         cfg_ff.steps_per_mm <= cpk_pkg::STEPS_PER_MM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/cpk_isqrt.sv */
// Iterative integer square root, two radicand bits per cycle (restoring digit recurrence).
// Depends on cpk_pkg for the radicand/root widths and step count.
module cpk_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cpk_pkg::RAD_W-1:0]     radicand,
   output logic                          done,
   output logic [cpk_pkg::ROOT_W-1:0]    root
);

   localparam int PAD_W = 2 * cpk_pkg::ROOT_W;
   localparam int REM_W = cpk_pkg::ROOT_W + 2;

   logic                              busy_ff;
   logic                              done_ff;
   logic [cpk_pkg::ISQRT_CNT_W-1:0]   cnt_ff;
   logic [PAD_W-1:0]                  rad_ff;
   logic [REM_W-1:0]                  rem_ff;
   logic [cpk_pkg::ROOT_W-1:0]        root_ff;

   logic [REM_W-1:0]                  rem_sh;
   logic [REM_W-1:0]                  trial;
   logic [REM_W-1:0]                  rem_in;
   logic [cpk_pkg::ROOT_W-1:0]        root_in;

   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[PAD_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_ff[cpk_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_ff[cpk_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == cpk_pkg::ISQRT_CNT_W'(cpk_pkg::ISQRT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= PAD_W'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[PAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* hw/rtl/cable_plotter_kinematics.sv */
// Top level of the cable plotter kinematics block: sequencer, shared multiplier, state.
// Depends on cpk_pkg, cpk_req_if, cpk_rsp_if, cpk_csr and cpk_isqrt.
//
// Usage:
//   req_bus carries one target point and an operation (move or set position).
//   rsp_bus returns one result per request: clamped point, both new cable lengths,
//   step counts and direction levels. Both use valid/ready; a transfer happens on a
//   rising edge with valid and ready high.
//   csr_we/csr_index/csr_wdata write the five configuration registers; write them
//   only while no request is in flight.
// Datapath and flow:
//   One 17x16 multiplier forms the three squares and both step products, and one
//   iterative root unit (one result bit per cycle) is run twice. req_bus.ready is
//   high only while the sequencer is idle, so a new request is not taken before
//   the last one has left the sequencer.
//   The result sits in an output register; the next request is accepted while it
//   waits. A stalled receiver holds the sequencer only when a second result is done.
// Reset:
//   Synchronous, active high. Stored lengths and held directions go to zero and the
//   configuration registers to their defaults.
module cable_plotter_kinematics (
   input  logic                              clock,
   input  logic                              reset,
   cpk_req_if.sink                           req_bus,
   cpk_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [cpk_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cpk_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DIFF_W = cpk_pkg::LEN_W + 1;
   localparam int OFS_W  = cpk_pkg::COORD_W + 2;
   localparam int SUM_W  = cpk_pkg::PROD_W + 1;
   localparam int SQ_W   = 2 * cpk_pkg::MAG_W;
   localparam int BY4_W  = SQ_W + 2;

   function automatic logic [OFS_W-2:0] abs_ofs(input logic signed [OFS_W-1:0] v);
      logic [OFS_W-1:0] m;
      m = v[OFS_W-1] ? OFS_W'(-v) : OFS_W'(v);
      return m[OFS_W-2:0];
   endfunction

   function automatic logic [cpk_pkg::STEP_W-1:0] ceil_sat(
      input logic [cpk_pkg::PROD_W-1:0] p);
      logic [SUM_W-1:0] s;
      logic [SUM_W-1:0] q;
      s = SUM_W'(p) + SUM_W'((SUM_W'(1) << cpk_pkg::STEP_SHIFT) - SUM_W'(1));
      q = s >> cpk_pkg::STEP_SHIFT;
      return (q > SUM_W'(cpk_pkg::STEP_MAX)) ? cpk_pkg::STEP_MAX : q[cpk_pkg::STEP_W-1:0];
   endfunction

   cpk_pkg::cpk_cfg_type cfg;

   cpk_pkg::cpk_state_type state_ff;
   cpk_pkg::cpk_state_type state_in;

   logic                                 op_ff;
   logic signed [cpk_pkg::COORD_W-1:0]   x_raw_ff;
   logic signed [cpk_pkg::COORD_W-1:0]   y_raw_ff;
   logic [cpk_pkg::CLAMP_W-1:0]          cx_ff;
   logic [cpk_pkg::CLAMP_W-1:0]          cy_ff;
   logic [cpk_pkg::MAG_W-1:0]            mag_l_ff;
   logic [cpk_pkg::MAG_W-1:0]            mag_r_ff;
   logic [cpk_pkg::MAG_W-1:0]            mag_y_ff;
   logic [BY4_W-1:0]                     by4_ff;
   logic [SQ_W-1:0]                      sq_l_ff;
   logic [SQ_W-1:0]                      sq_r_ff;
   logic [cpk_pkg::LEN_W-1:0]            len_l_ff;
   logic [cpk_pkg::LEN_W-1:0]            len_r_ff;
   logic [cpk_pkg::LEN_W-1:0]            dmag_l_ff;
   logic [cpk_pkg::LEN_W-1:0]            dmag_r_ff;
   logic                                 dpos_l_ff;
   logic                                 dpos_r_ff;
   logic [cpk_pkg::PROD_W-1:0]           p_l_ff;
   logic [cpk_pkg::PROD_W-1:0]           p_r_ff;

   logic [cpk_pkg::LEN_W-1:0]            len_l_now_ff;
   logic [cpk_pkg::LEN_W-1:0]            len_r_now_ff;
   logic                                 dir_l_ff;
   logic                                 dir_r_ff;
   logic                                 dir_l_in;
   logic                                 dir_r_in;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [cpk_pkg::CLAMP_W-1:0]          rsp_cx_ff;
   logic [cpk_pkg::CLAMP_W-1:0]          rsp_cy_ff;
   logic [cpk_pkg::LEN_W-1:0]            rsp_len_l_ff;
   logic [cpk_pkg::LEN_W-1:0]            rsp_len_r_ff;
   logic [cpk_pkg::STEP_W-1:0]           rsp_step_l_ff;
   logic [cpk_pkg::STEP_W-1:0]           rsp_step_r_ff;
   logic [cpk_pkg::STEP_W-1:0]           step_l_in;
   logic [cpk_pkg::STEP_W-1:0]           step_r_in;

   logic                                 req_fire;
   logic                                 out_free;
   logic                                 finish_fire;

   logic [cpk_pkg::LEN_W-1:0]            mul_a;
   logic [cpk_pkg::SPM_W-1:0]            mul_b;
   logic [cpk_pkg::PROD_W-1:0]           mul_p;

   logic [cpk_pkg::CLAMP_W-1:0]          cx_in;
   logic [cpk_pkg::CLAMP_W-1:0]          cy_in;
   logic signed [OFS_W-1:0]              ofs_l;
   logic signed [OFS_W-1:0]              ofs_r;
   logic signed [OFS_W-1:0]              ofs_y;
   logic [cpk_pkg::CLAMP_W-1:0]          w_minus_x;
   logic signed [DIFF_W-1:0]             dl;
   logic signed [DIFF_W-1:0]             dr;

   logic                                 sq_start;
   logic [cpk_pkg::RAD_W-1:0]            sq_rad;
   logic                                 sq_done;
   logic [cpk_pkg::ROOT_W-1:0]           sq_root;

   cpk_csr u_csr (
      .clock (clock),
      .reset (reset),
      .we    (csr_we),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   cpk_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign req_fire    = req_bus.valid && req_bus.ready;
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign finish_fire = (state_ff == cpk_pkg::S_FINISH) && out_free;

   // clamp and anchor offsets; the right offset works in doubled units like the left
   always_comb begin
      if ($signed({x_raw_ff[cpk_pkg::COORD_W-1], x_raw_ff}) >
          $signed({2'b00, cfg.board_width}))
         cx_in = cfg.board_width;
      else if (x_raw_ff[cpk_pkg::COORD_W-1])
         cx_in = '0;
      else
         cx_in = x_raw_ff[cpk_pkg::CLAMP_W-1:0];
      if ($signed({y_raw_ff[cpk_pkg::COORD_W-1], y_raw_ff}) >
          $signed({2'b00, cfg.board_height}))
         cy_in = cfg.board_height;
      else if (y_raw_ff[cpk_pkg::COORD_W-1])
         cy_in = '0;
      else
         cy_in = y_raw_ff[cpk_pkg::CLAMP_W-1:0];
      w_minus_x = cfg.board_width - cx_in;
      ofs_l = $signed({2'b00, cx_in, 1'b0}) - $signed({3'b000, cfg.anchor_gap});
      ofs_r = $signed({2'b00, w_minus_x, 1'b0}) - $signed({3'b000, cfg.anchor_gap});
      ofs_y = $signed({3'b000, cy_in}) -
              $signed({{2{cfg.anchor_y[cpk_pkg::COORD_W-1]}}, cfg.anchor_y});
      dl = $signed({1'b0, len_l_ff}) - $signed({1'b0, len_l_now_ff});
      dr = $signed({1'b0, len_r_ff}) - $signed({1'b0, len_r_now_ff});
   end

   // shared multiplier
   always_comb begin
      case (state_ff)
         cpk_pkg::S_SQ_Y: begin
            mul_a = cpk_pkg::LEN_W'(mag_y_ff);
            mul_b = mag_y_ff;
         end
         cpk_pkg::S_SQ_L: begin
            mul_a = cpk_pkg::LEN_W'(mag_l_ff);
            mul_b = mag_l_ff;
         end
         cpk_pkg::S_SQ_R: begin
            mul_a = cpk_pkg::LEN_W'(mag_r_ff);
            mul_b = mag_r_ff;
         end
         cpk_pkg::S_STEP_L: begin
            mul_a = dmag_l_ff;
            mul_b = cfg.steps_per_mm;
         end
         cpk_pkg::S_STEP_R: begin
            mul_a = dmag_r_ff;
            mul_b = cfg.steps_per_mm;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = cpk_pkg::PROD_W'(mul_a) * cpk_pkg::PROD_W'(mul_b);
   end

   assign sq_start = (state_ff == cpk_pkg::S_RL_GO) || (state_ff == cpk_pkg::S_RR_GO);
   assign sq_rad   = (state_ff == cpk_pkg::S_RR_GO) ?
                     cpk_pkg::RAD_W'(sq_r_ff) + cpk_pkg::RAD_W'(by4_ff) :
                     cpk_pkg::RAD_W'(sq_l_ff) + cpk_pkg::RAD_W'(by4_ff);

   // next state and result assembly
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpk_pkg::S_IDLE:    if (req_fire) state_in = cpk_pkg::S_CLAMP;
         cpk_pkg::S_CLAMP:   state_in = cpk_pkg::S_SQ_Y;
         cpk_pkg::S_SQ_Y:    state_in = cpk_pkg::S_SQ_L;
         cpk_pkg::S_SQ_L:    state_in = cpk_pkg::S_SQ_R;
         cpk_pkg::S_SQ_R:    state_in = cpk_pkg::S_RL_GO;
         cpk_pkg::S_RL_GO:   state_in = cpk_pkg::S_RL_WAIT;
         cpk_pkg::S_RL_WAIT: if (sq_done) state_in = cpk_pkg::S_RR_GO;
         cpk_pkg::S_RR_GO:   state_in = cpk_pkg::S_RR_WAIT;
         cpk_pkg::S_RR_WAIT: if (sq_done) state_in = cpk_pkg::S_DIFF;
         cpk_pkg::S_DIFF:    state_in = cpk_pkg::S_STEP_L;
         cpk_pkg::S_STEP_L:  state_in = cpk_pkg::S_STEP_R;
         cpk_pkg::S_STEP_R:  state_in = cpk_pkg::S_FINISH;
         cpk_pkg::S_FINISH:  if (out_free) state_in = cpk_pkg::S_IDLE;
         default:            state_in = cpk_pkg::S_IDLE;
      endcase

      if (op_ff == cpk_pkg::OP_MOVE) begin
         step_l_in = ceil_sat(p_l_ff);
         step_r_in = ceil_sat(p_r_ff);
         dir_l_in  = (p_l_ff != '0) ? dpos_l_ff : dir_l_ff;
         dir_r_in  = (p_r_ff != '0) ? !dpos_r_ff : dir_r_ff;
      end else begin
         step_l_in = '0;
         step_r_in = '0;
         dir_l_in  = dir_l_ff;
         dir_r_in  = dir_r_ff;
      end

      if (finish_fire)
         rsp_valid_in = 1'b1;
      else if (rsp_bus.ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpk_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         len_l_now_ff <= '0;
         len_r_now_ff <= '0;
         dir_l_ff     <= 1'b0;
         dir_r_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish_fire) begin
            len_l_now_ff <= len_l_ff;
            len_r_now_ff <= len_r_ff;
            dir_l_ff     <= dir_l_in;
            dir_r_ff     <= dir_r_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         cpk_pkg::S_IDLE: begin
            if (req_fire) begin
               op_ff    <= req_bus.operation;
               x_raw_ff <= req_bus.target_x;
               y_raw_ff <= req_bus.target_y;
            end
         end
         cpk_pkg::S_CLAMP: begin
            cx_ff    <= cx_in;
            cy_ff    <= cy_in;
            mag_l_ff <= cpk_pkg::MAG_W'(abs_ofs(ofs_l));
            mag_r_ff <= cpk_pkg::MAG_W'(abs_ofs(ofs_r));
            mag_y_ff <= cpk_pkg::MAG_W'(abs_ofs(ofs_y));
         end
         cpk_pkg::S_SQ_Y:    by4_ff  <= {mul_p[SQ_W-1:0], 2'b00};
         cpk_pkg::S_SQ_L:    sq_l_ff <= mul_p[SQ_W-1:0];
         cpk_pkg::S_SQ_R:    sq_r_ff <= mul_p[SQ_W-1:0];
         cpk_pkg::S_RL_WAIT: if (sq_done) len_l_ff <= sq_root[cpk_pkg::ROOT_W-1:1];
         cpk_pkg::S_RR_WAIT: if (sq_done) len_r_ff <= sq_root[cpk_pkg::ROOT_W-1:1];
         cpk_pkg::S_DIFF: begin
            dmag_l_ff <= dl[DIFF_W-1] ? cpk_pkg::LEN_W'(-dl) : cpk_pkg::LEN_W'(dl);
            dmag_r_ff <= dr[DIFF_W-1] ? cpk_pkg::LEN_W'(-dr) : cpk_pkg::LEN_W'(dr);
            dpos_l_ff <= !dl[DIFF_W-1] && (dl != '0);
            dpos_r_ff <= !dr[DIFF_W-1] && (dr != '0);
         end
         cpk_pkg::S_STEP_L:  p_l_ff <= mul_p;
         cpk_pkg::S_STEP_R:  p_r_ff <= mul_p;
         default: ;
      endcase
      if (finish_fire) begin
         rsp_cx_ff     <= cx_ff;
         rsp_cy_ff     <= cy_ff;
         rsp_len_l_ff  <= len_l_ff;
         rsp_len_r_ff  <= len_r_ff;
         rsp_step_l_ff <= step_l_in;
         rsp_step_r_ff <= step_r_in;
      end
   end

   assign req_bus.ready            = (state_ff == cpk_pkg::S_IDLE);
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.clamped_x        = rsp_cx_ff;
   assign rsp_bus.clamped_y        = rsp_cy_ff;
   assign rsp_bus.new_length_left  = rsp_len_l_ff;
   assign rsp_bus.new_length_right = rsp_len_r_ff;
   assign rsp_bus.step_count_left  = rsp_step_l_ff;
   assign rsp_bus.step_count_right = rsp_step_r_ff;
   assign rsp_bus.dir_level_left   = dir_l_ff;
   assign rsp_bus.dir_level_right  = dir_r_ff;

   // root unit only reports while the sequencer waits for it
   a_root_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == cpk_pkg::S_RL_WAIT || state_ff == cpk_pkg::S_RR_WAIT))
      else $error("root unit finished outside a wait state");

   a_finish_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      finish_fire |=> rsp_valid_ff && state_ff == cpk_pkg::S_IDLE)
      else $error("finished request did not reach the response register");

   a_set_keeps_dir: assert property (@(posedge clock) disable iff (reset)
      (finish_fire && op_ff == cpk_pkg::OP_SET) |=> $stable(dir_l_ff) && $stable(dir_r_ff))
      else $error("set position changed a direction level");

   a_set_no_steps: assert property (@(posedge clock) disable iff (reset)
      (finish_fire && op_ff == cpk_pkg::OP_SET) |=>
         rsp_step_l_ff == '0 && rsp_step_r_ff == '0)
      else $error("set position reported steps");

endmodule

/* sim/cable_plotter_kinematics_tb.sv */
// Self-checking bench for cable_plotter_kinematics: directed table, then random targets
// over several board settings, each response checked against its typed row or an in-bench cable predictor.
// Depends on cpk_pkg, cpk_req_if, cpk_rsp_if and the cable_plotter_kinematics RTL.
module cable_plotter_kinematics_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cpk_pkg::*;

   localparam int PHASE_ITEMS   = 70;
   localparam int STEADY_ITEMS  = 25;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 2 * ISQRT_STEPS + 13 + 20;

   typedef struct packed {
      logic [CLAMP_W-1:0] clamped_x;
      logic [CLAMP_W-1:0] clamped_y;
      logic [LEN_W-1:0]   new_length_left;
      logic [LEN_W-1:0]   new_length_right;
      logic [STEP_W-1:0]  step_count_left;
      logic [STEP_W-1:0]  step_count_right;
      logic               dir_level_left;
      logic               dir_level_right;
   } cable_result_t;

   typedef struct packed {
      logic                      op;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      typed;
      cable_result_t             want;
   } target_row_t;

   localparam int DIRECTED_ROWS = 20;

   // first row: move straight after reset, measured from zero lengths
   target_row_t directed_rows [DIRECTED_ROWS] = '{
      '{OP_MOVE, 16'sd0, 16'sd0, 1'b1,
        '{15'd0, 15'd0, 17'd0, 17'd16000, 21'd0, 21'd5000, 1'b0, 1'b0}},
      '{OP_SET, 16'sd0, 16'sd0, 1'b1,
        '{15'd0, 15'd0, 17'd0, 17'd16000, 21'd0, 21'd0, 1'b0, 1'b0}},
      '{OP_MOVE, 16'sd0, 16'sd0, 1'b1,
        '{15'd0, 15'd0, 17'd0, 17'd16000, 21'd0, 21'd0, 1'b0, 1'b0}},
      '{OP_MOVE, 16'sh7FFF, 16'sh7FFF, 1'b1,
        '{15'd16000, 15'd16000, 17'd22627, 17'd16000, 21'd7071, 21'd0, 1'b1, 1'b0}},
      '{OP_MOVE, 16'sh8000, 16'sh8000, 1'b1,
        '{15'd0, 15'd0, 17'd0, 17'd16000, 21'd7071, 21'd0, 1'b0, 1'b0}},
      '{OP_MOVE, 16'sd16000, 16'sd0, 1'b0, '0},
      '{OP_MOVE, 16'sd8000, 16'sd8000, 1'b0, '0},
      '{OP_SET, 16'sd1, 16'sd1, 1'b0, '0},
      '{OP_MOVE, 16'sd2, 16'sd1, 1'b0, '0},
      '{OP_MOVE, 16'sh7FFF, 16'sh8000, 1'b0, '0},
      '{OP_MOVE, 16'sh8000, 16'sh7FFF, 1'b0, '0},
      '{OP_SET, 16'shFFFF, 16'shFFFF, 1'b0, '0},
      '{OP_MOVE, 16'sd16001, 16'sd16001, 1'b0, '0},
      '{OP_MOVE, 16'sd15999, 16'sd15999, 1'b0, '0},
      '{OP_MOVE, 16'sd12345, 16'sd321, 1'b0, '0},
      '{OP_MOVE, 16'sd1, 16'sd0, 1'b0, '0},
      '{OP_SET, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
      '{OP_MOVE, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
      '{OP_MOVE, 16'sh5555, 16'sh2AAA, 1'b0, '0},
      '{OP_MOVE, 16'shAAAA, 16'sh5555, 1'b0, '0}
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   cpk_req_if req_bus ();
   cpk_rsp_if rsp_bus ();

   cable_plotter_kinematics dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cpk_cfg_type       board_cfg;
   logic [LEN_W-1:0]  left_span_now;
   logic [LEN_W-1:0]  right_span_now;
   logic              left_dir_now;
   logic              right_dir_now;

   cable_result_t cable_results_due [$];
   bit steady_flow;
   int requests_sent;
   int set_requests;
   int results_checked;
   int board_settings;
   int failures;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // floor(sqrt((twice_dx/2)^2 + dy^2)), kept exact by working on doubled units
   function automatic logic [LEN_W-1:0] cable_span(input longint twice_dx, input longint dy);
      longint unsigned a, b, s, root, trial;
      a = (twice_dx < 0) ? -twice_dx : twice_dx;
      b = (dy < 0) ? -dy : dy;
      s = a * a + 64'd4 * b * b;
      root = 0;
      for (int i = 19; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= s) root = trial;
      end
      return LEN_W'(root >> 1);
   endfunction

   function automatic logic [STEP_W-1:0] step_total(input longint change, output bit moved);
      longint unsigned mag, prod, up;
      mag = (change < 0) ? -change : change;
      prod = mag * board_cfg.steps_per_mm;
      moved = (prod != 0);
      up = (prod + (64'd1 << STEP_SHIFT) - 64'd1) >> STEP_SHIFT;
      return (up > STEP_MAX) ? STEP_MAX : STEP_W'(up);
   endfunction

   function automatic cable_result_t solve_cables(input logic op,
                                                  input logic signed [COORD_W-1:0] tx,
                                                  input logic signed [COORD_W-1:0] ty);
      longint x, y, w, h, g, dy, dl, dr;
      bit moved_l, moved_r;
      cable_result_t r;
      w = longint'(board_cfg.board_width);
      h = longint'(board_cfg.board_height);
      g = longint'(board_cfg.anchor_gap);
      x = tx;
      y = ty;
      if (x > w) x = w;
      else if (x < 0) x = 0;
      if (y > h) y = h;
      else if (y < 0) y = 0;
      dy = y - longint'($signed(board_cfg.anchor_y));
      r.clamped_x = CLAMP_W'(x);
      r.clamped_y = CLAMP_W'(y);
      r.new_length_left = cable_span(2 * x - g, dy);
      r.new_length_right = cable_span(2 * (w - x) - g, dy);
      r.step_count_left = '0;
      r.step_count_right = '0;
      if (op == OP_MOVE) begin
         dl = longint'(r.new_length_left) - longint'(left_span_now);
         dr = longint'(r.new_length_right) - longint'(right_span_now);
         r.step_count_left = step_total(dl, moved_l);
         r.step_count_right = step_total(dr, moved_r);
         if (moved_l) left_dir_now = (dl > 0);
         if (moved_r) right_dir_now = !(dr > 0);
      end
      left_span_now = r.new_length_left;
      right_span_now = r.new_length_right;
      r.dir_level_left = left_dir_now;
      r.dir_level_right = right_dir_now;
      return r;
   endfunction

   function automatic int pause_cycles();
      return steady_flow ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord(input logic [CLAMP_W-1:0] limit);
      case ($urandom_range(0, 7))
         0, 1: return COORD_W'($urandom);
         2: return COORD_W'(int'(limit) + int'($urandom_range(0, 2)) - 1);
         default: return COORD_W'($urandom_range(0, int'(limit)));
      endcase
   endfunction

   task automatic issue_request(input logic op, input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y, input logic typed,
                                input cable_result_t want);
      int gap;
      cable_result_t predicted;
      gap = pause_cycles();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.target_x <= x;
      req_bus.target_y <= y;
      do @(posedge clock); while (!req_bus.ready);
      predicted = solve_cables(op, x, y);
      cable_results_due.push_back(typed ? want : predicted);
      requests_sent++;
      if (op == OP_SET) set_requests++;
   endtask

   task automatic wait_idle(input int extra);
      req_bus.valid <= 1'b0;
      while (cable_results_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // leaves csr_we high so back-to-back writes need one assignment per edge
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         REG_BOARD_WIDTH:  board_cfg.board_width = data[CLAMP_W-1:0];
         REG_BOARD_HEIGHT: board_cfg.board_height = data[CLAMP_W-1:0];
         REG_ANCHOR_Y:     board_cfg.anchor_y = data;
         REG_ANCHOR_GAP:   board_cfg.anchor_gap = data[CLAMP_W-1:0];
         REG_STEPS_PER_MM: board_cfg.steps_per_mm = data;
         default: ;
      endcase
   endtask

   task automatic program_board(input logic [CSR_DATA_W-1:0] width, input logic [CSR_DATA_W-1:0] height,
                                input logic [CSR_DATA_W-1:0] anchor, input logic [CSR_DATA_W-1:0] gap,
                                input logic [CSR_DATA_W-1:0] spm);
      wait_idle(SETTLE_CYCLES);
      csr_write(REG_BOARD_WIDTH, width);
      csr_write(REG_BOARD_HEIGHT, height);
      csr_write(REG_ANCHOR_Y, anchor);
      csr_write(REG_ANCHOR_GAP, gap);
      csr_write(REG_STEPS_PER_MM, spm);
      csr_we <= 1'b0;
      board_settings++;
   endtask

   task automatic random_targets(input int count);
      logic op;
      for (int n = 0; n < count; n++) begin
         steady_flow = (n < STEADY_ITEMS);
         op = ($urandom_range(0, 7) == 0) ? OP_SET : OP_MOVE;
         issue_request(op, pick_coord(board_cfg.board_width),
                       pick_coord(board_cfg.board_height), 1'b0, '0);
      end
      steady_flow = 1'b0;
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic check_result();
      cable_result_t want;
      if (cable_results_due.size() == 0) begin
         $error("response with no request outstanding");
         failures++;
         return;
      end
      want = cable_results_due.pop_front();
      results_checked++;
      check_field("clamped_x", want.clamped_x, rsp_bus.clamped_x);
      check_field("clamped_y", want.clamped_y, rsp_bus.clamped_y);
      check_field("new_length_left", want.new_length_left, rsp_bus.new_length_left);
      check_field("new_length_right", want.new_length_right, rsp_bus.new_length_right);
      check_field("step_count_left", want.step_count_left, rsp_bus.step_count_left);
      check_field("step_count_right", want.step_count_right, rsp_bus.step_count_right);
      check_field("dir_level_left", want.dir_level_left, rsp_bus.dir_level_left);
      check_field("dir_level_right", want.dir_level_right, rsp_bus.dir_level_right);
   endtask

   initial begin : response_side
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result();
            stall = pause_cycles();
            // long back-pressure so the block fills and stalls its request side
            if (results_checked == 120 || results_checked == 420) stall = LONG_HOLD;
            if (stall != 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   initial begin : request_side
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.operation <= OP_MOVE;
      req_bus.target_x <= '0;
      req_bus.target_y <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_BOARD_WIDTH;
      csr_wdata <= '0;
      board_cfg = '{BOARD_WIDTH_RST, BOARD_HEIGHT_RST, ANCHOR_Y_RST, ANCHOR_GAP_RST,
                    STEPS_PER_MM_RST};
      left_span_now = '0;
      right_span_now = '0;
      left_dir_now = 1'b0;
      right_dir_now = 1'b0;
      steady_flow = 1'b0;
      requests_sent = 0;
      set_requests = 0;
      results_checked = 0;
      board_settings = 1;
      failures = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue_request(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                       directed_rows[i].typed, directed_rows[i].want);

      program_board(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
      random_targets(PHASE_ITEMS);
      // empty board, zero scale: every step count zero, directions held
      program_board(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
      random_targets(PHASE_ITEMS);
      // anchor gap wider than the board
      program_board(16'd200, 16'd3000, 16'd1500, 16'd30000, 16'd1);
      random_targets(PHASE_ITEMS);
      repeat (3) begin
         program_board(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
         random_targets(PHASE_ITEMS);
      end
      program_board(16'd16000, 16'd16000, 16'd0, 16'd0, 16'd1280);
      random_targets(PHASE_ITEMS);

      wait_idle(TAIL_CYCLES);
      $display("Sent %0d requests (%0d set-position, %0d from the directed table)",
               requests_sent, set_requests, DIRECTED_ROWS);
      $display("over %0d board settings; %0d responses compared.",
               board_settings, results_checked);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/cpk_pkg.sv
hw/rtl/cpk_req_if.sv
hw/rtl/cpk_rsp_if.sv
hw/rtl/cpk_csr.sv
hw/rtl/cpk_isqrt.sv
hw/rtl/cable_plotter_kinematics.sv
sim/cable_plotter_kinematics_tb.sv
